// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/bsac_pkg.sv =====
// Package with the constants, types and codes of the banked cache tag store.
`timescale 1ns / 1ps
package bsac_pkg;
	localparam int NUM_WAYS = 4;
	localparam int NUM_BANKS = 4;
	localparam int SETS_PER_BANK = 64;
	localparam int OFFSET_BITS = 3;
	localparam int ADDR_W = 32;
	localparam int WAY_W = $clog2(NUM_WAYS);
	localparam int BANK_W = $clog2(NUM_BANKS);
	localparam int SET_W = $clog2(SETS_PER_BANK);
	localparam int TAG_W = ADDR_W - OFFSET_BITS - BANK_W - SET_W;
	localparam int ROWS = NUM_BANKS * SETS_PER_BANK;
	localparam int ROW_W = $clog2(ROWS);
	localparam int AGE_W = $clog2(NUM_WAYS + 1);
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_WRITE = 2'd1,
		OP_FILL = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		POL_RANDOM = 2'd0,
		POL_LRU = 2'd1,
		POL_FIFO = 2'd2,
		POL_SPARE = 2'd3
	} pol_t;

	typedef enum logic {
		WP_THROUGH = 1'b0,
		WP_BACK = 1'b1
	} wpol_t;

	typedef enum logic {
		REG_REPLACE = 1'b0,
		REG_WRITE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic valid;
		logic dirty;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] tag_row_t;
	typedef logic [NUM_WAYS-1:0][AGE_W-1:0] age_row_t;
endpackage

// ===== rtl/bsac_req_if.sv =====
// Request channel interface carrying one lookup or fill item.
`timescale 1ns / 1ps
interface bsac_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [31:0] word_address;
	modport source (output valid, operation, word_address, input ready);
	modport sink (input valid, operation, word_address, output ready);
endinterface

// ===== rtl/bsac_rsp_if.sv =====
// Result channel interface carrying one result item.
`timescale 1ns / 1ps
interface bsac_rsp_if;
	logic valid;
	logic ready;
	logic hit;
	logic [1:0] way_used;
	logic writeback_valid;
	logic [31:0] writeback_address;
	logic writethrough_valid;
	logic [31:0] writethrough_address;
	modport source (output valid, hit, way_used, writeback_valid, writeback_address,
		writethrough_valid, writethrough_address, input ready);
	modport sink (input valid, hit, way_used, writeback_valid, writeback_address,
		writethrough_valid, writethrough_address, output ready);
endinterface

// ===== rtl/bsac_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module bsac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/banked_set_assoc_cache_tags_core.sv =====
// An item is read from the tag and age RAMs when it is accepted and resolved in the lookup state.
// The result is registered when the lookup state advances, which a held result can stall.
// Each item reads and then writes one RAM row, so a new item is taken only after the last one is done.
// One item is in progress at a time; a held result stalls the lookup state.
// Reset clears a valid flag per row in flip-flops, so every row reads as empty at once.
// Reset also loads the random generator seed and the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module banked_set_assoc_cache_tags_core (
	input logic clk,
	input logic arst_n,
	bsac_req_if.sink req,
	bsac_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	bsac_pkg::state_t state_q, state_next;
	logic [1:0] replace_q;
	logic write_pol_q;
	logic [15:0] lfsr_q, lfsr_next;
	logic [bsac_pkg::ROWS-1:0] rowv_q;
	logic rowv_s1;
	logic [1:0] op_s1;
	logic [31:0] addr_s1;
	logic accept, advance, ram_we;
	logic [bsac_pkg::ROW_W-1:0] rd_row, row_s1;
	bsac_pkg::tag_row_t tags_rd, tags_cur, tags_new;
	bsac_pkg::age_row_t ages_rd, ages_cur, ages_new;
	logic [bsac_pkg::TAG_W-1:0] tag_s1;
	logic [bsac_pkg::SET_W-1:0] set_s1;
	logic [bsac_pkg::BANK_W-1:0] bank_s1;
	logic hit_c, wb_c, wt_c;
	logic [bsac_pkg::WAY_W-1:0] way_c;
	logic [31:0] wb_addr_c;
	logic rsp_valid_q, hit_q, wb_q, wt_q;
	logic [bsac_pkg::WAY_W-1:0] way_q;
	logic [31:0] wb_addr_q, wt_addr_q;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		case (bsac_pkg::reg_idx_t'(paddr[2]))
			bsac_pkg::REG_REPLACE: prdata = {30'd0, replace_q};
			bsac_pkg::REG_WRITE: prdata = {31'd0, write_pol_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_q <= bsac_pkg::POL_LRU;
			write_pol_q <= bsac_pkg::WP_BACK;
		end else if (psel && penable && pwrite) begin
			case (bsac_pkg::reg_idx_t'(paddr[2]))
				bsac_pkg::REG_REPLACE: replace_q <= pwdata[1:0];
				bsac_pkg::REG_WRITE: write_pol_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			bsac_pkg::ST_IDLE: if (req.valid) state_next = bsac_pkg::ST_LOOK;
			bsac_pkg::ST_LOOK: if (advance) state_next = bsac_pkg::ST_IDLE;
			default: state_next = bsac_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		advance = 1'b0;
		case (state_q)
			bsac_pkg::ST_IDLE: req.ready = 1'b1;
			bsac_pkg::ST_LOOK: advance = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;
	assign rd_row = req.word_address[bsac_pkg::OFFSET_BITS +: bsac_pkg::ROW_W];
	assign row_s1 = addr_s1[bsac_pkg::OFFSET_BITS +: bsac_pkg::ROW_W];
	assign bank_s1 = addr_s1[bsac_pkg::OFFSET_BITS +: bsac_pkg::BANK_W];
	assign set_s1 = addr_s1[bsac_pkg::OFFSET_BITS + bsac_pkg::BANK_W +: bsac_pkg::SET_W];
	assign tag_s1 = addr_s1[31 -: bsac_pkg::TAG_W];
	assign ram_we = advance && (bsac_pkg::op_t'(op_s1) != bsac_pkg::OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsac_pkg::ST_IDLE;
			rowv_q <= '0;
			lfsr_q <= bsac_pkg::LFSR_SEED;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ram_we) rowv_q[row_s1] <= 1'b1;
			if (advance) begin
				lfsr_q <= lfsr_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.operation;
			addr_s1 <= req.word_address;
			rowv_s1 <= rowv_q[rd_row];
		end
		if (advance) begin
			hit_q <= hit_c;
			way_q <= way_c;
			wb_q <= wb_c;
			wb_addr_q <= wb_addr_c;
			wt_q <= wt_c;
			wt_addr_q <= wt_c ? addr_s1 : 32'd0;
		end
	end

	bsac_ram #(.WIDTH($bits(bsac_pkg::tag_row_t)), .DEPTH(bsac_pkg::ROWS)) u_tag_ram (
		.clk(clk), .we(ram_we), .waddr(row_s1), .wdata(tags_new),
		.re(accept), .raddr(rd_row), .rdata(tags_rd)
	);

	bsac_ram #(.WIDTH($bits(bsac_pkg::age_row_t)), .DEPTH(bsac_pkg::ROWS)) u_age_ram (
		.clk(clk), .we(ram_we), .waddr(row_s1), .wdata(ages_new),
		.re(accept), .raddr(rd_row), .rdata(ages_rd)
	);

	always_comb begin
		logic [1:0] pol;
		logic [bsac_pkg::AGE_W-1:0] a, best;
		logic [bsac_pkg::WAY_W-1:0] v;
		tags_cur = rowv_s1 ? tags_rd : '0;
		ages_cur = rowv_s1 ? ages_rd : '0;
		tags_new = tags_cur;
		ages_new = ages_cur;
		pol = (replace_q == bsac_pkg::POL_SPARE) ? bsac_pkg::POL_LRU : replace_q;
		lfsr_next = lfsr_q;
		hit_c = 1'b0;
		way_c = '0;
		wb_c = 1'b0;
		wb_addr_c = '0;
		wt_c = 1'b0;
		v = '0;
		best = bsac_pkg::AGE_W'(bsac_pkg::NUM_WAYS);
		a = '0;
		case (bsac_pkg::op_t'(op_s1))
			bsac_pkg::OP_READ, bsac_pkg::OP_WRITE: begin
				for (int i = 0; i < bsac_pkg::NUM_WAYS; i++) begin
					if (tags_cur[i].valid && tags_cur[i].tag == tag_s1) begin
						hit_c = 1'b1;
						way_c = bsac_pkg::WAY_W'(i);
					end
				end
				if (hit_c) begin
					a = ages_cur[way_c];
					if (pol == bsac_pkg::POL_LRU &&
						a != bsac_pkg::AGE_W'(bsac_pkg::NUM_WAYS - 1)) begin
						for (int i = 0; i < bsac_pkg::NUM_WAYS; i++) begin
							if (ages_cur[i] > a) ages_new[i] = ages_cur[i] - 1'b1;
						end
						ages_new[way_c] = bsac_pkg::AGE_W'(bsac_pkg::NUM_WAYS - 1);
					end
					if (bsac_pkg::op_t'(op_s1) == bsac_pkg::OP_WRITE) begin
						tags_new[way_c].dirty = 1'b1;
						wt_c = (write_pol_q == bsac_pkg::WP_THROUGH);
					end
				end
			end
			bsac_pkg::OP_FILL: begin
				case (pol)
					bsac_pkg::POL_RANDOM: begin
						lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ bsac_pkg::LFSR_TAPS)
							: (lfsr_q >> 1);
						v = lfsr_next[bsac_pkg::WAY_W-1:0];
					end
					bsac_pkg::POL_FIFO: begin
						for (int i = 0; i < bsac_pkg::NUM_WAYS; i++) begin
							if (ages_cur[i] == '0) v = bsac_pkg::WAY_W'(i);
						end
					end
					default: begin
						for (int i = 0; i < bsac_pkg::NUM_WAYS; i++) begin
							if (ages_cur[i] < best) begin
								best = ages_cur[i];
								v = bsac_pkg::WAY_W'(i);
							end
						end
					end
				endcase
				way_c = v;
				if (write_pol_q == bsac_pkg::WP_BACK && tags_cur[v].valid && tags_cur[v].dirty) begin
					wb_c = 1'b1;
					wb_addr_c = {tags_cur[v].tag, set_s1, bank_s1,
						{bsac_pkg::OFFSET_BITS{1'b0}}};
				end
				tags_new[v].tag = tag_s1;
				tags_new[v].valid = 1'b1;
				tags_new[v].dirty = 1'b0;
				if (pol != bsac_pkg::POL_RANDOM) begin
					ages_new[v] = bsac_pkg::AGE_W'(bsac_pkg::NUM_WAYS);
					for (int i = 0; i < bsac_pkg::NUM_WAYS; i++) begin
						if (ages_new[i] != '0) ages_new[i] = ages_new[i] - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.hit = hit_q;
	assign rsp.way_used = way_q;
	assign rsp.writeback_valid = wb_q;
	assign rsp.writeback_address = wb_addr_q;
	assign rsp.writethrough_valid = wt_q;
	assign rsp.writethrough_address = wt_addr_q;

	`ASSERT_NEXT(a_accept_look, accept, state_q == bsac_pkg::ST_LOOK, "accepted item not in lookup")
	`ASSERT_IMPLY(a_lfsr_nonzero, 1'b1, lfsr_q != 16'd0, "random generator reached zero")
	`ASSERT_IMPLY(a_hit_no_wb, rsp_valid_q && hit_q, !wb_q, "hit result carries a write-back")
	`ASSERT_IMPLY(a_wt_needs_hit, rsp_valid_q && wt_q, hit_q, "write-through without a hit")
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the banked cache tag store: predicts each result and compares it.
`timescale 1ns / 1ps
module testbench;
	typedef struct {
		logic hit;
		logic [1:0] way;
		logic wb_valid;
		logic [31:0] wb_addr;
		logic wt_valid;
		logic [31:0] wt_addr;
	} tag_result_t;

	class tag_scoreboard;
		bsac_pkg::line_t lines [bsac_pkg::ROWS][bsac_pkg::NUM_WAYS];
		logic [bsac_pkg::AGE_W-1:0] ages [bsac_pkg::ROWS][bsac_pkg::NUM_WAYS];
		logic [15:0] lfsr;
		bsac_pkg::pol_t replace_pol;
		bsac_pkg::wpol_t write_pol;
		tag_result_t pending [$];
		int errors;

		function new();
			foreach (lines[r, w]) begin
				lines[r][w] = '0;
				ages[r][w] = '0;
			end
			lfsr = bsac_pkg::LFSR_SEED;
			replace_pol = bsac_pkg::POL_LRU;
			write_pol = bsac_pkg::WP_BACK;
			errors = 0;
		endfunction

		function void promote(int row, int way);
			logic [bsac_pkg::AGE_W-1:0] a;
			a = ages[row][way];
			if (a == bsac_pkg::NUM_WAYS - 1)
				return;
			for (int i = 0; i < bsac_pkg::NUM_WAYS; i++)
				if (ages[row][i] > a)
					ages[row][i]--;
			ages[row][way] = bsac_pkg::AGE_W'(bsac_pkg::NUM_WAYS - 1);
		endfunction

		function int choose_victim(bsac_pkg::pol_t pol, int row);
			int v;
			int best;
			v = 0;
			best = bsac_pkg::NUM_WAYS;
			if (pol == bsac_pkg::POL_RANDOM) begin
				lfsr = lfsr[0] ? ((lfsr >> 1) ^ bsac_pkg::LFSR_TAPS) : (lfsr >> 1);
				return lfsr % bsac_pkg::NUM_WAYS;
			end
			if (pol == bsac_pkg::POL_FIFO) begin
				for (int i = 0; i < bsac_pkg::NUM_WAYS; i++)
					if (ages[row][i] == 0)
						v = i;
				return v;
			end
			for (int i = 0; i < bsac_pkg::NUM_WAYS; i++)
				if (ages[row][i] < best) begin
					best = ages[row][i];
					v = i;
				end
			return v;
		endfunction

		function void note_request(bsac_pkg::op_t op, logic [31:0] addr);
			tag_result_t r;
			logic [bsac_pkg::BANK_W-1:0] bank;
			logic [bsac_pkg::SET_W-1:0] set_idx;
			logic [bsac_pkg::TAG_W-1:0] tag;
			bsac_pkg::pol_t pol;
			int row;
			int v;
			r = '{default: '0};
			bank = addr[bsac_pkg::OFFSET_BITS +: bsac_pkg::BANK_W];
			set_idx = addr[bsac_pkg::OFFSET_BITS + bsac_pkg::BANK_W +: bsac_pkg::SET_W];
			tag = addr[bsac_pkg::ADDR_W-1 -: bsac_pkg::TAG_W];
			row = bank * bsac_pkg::SETS_PER_BANK + set_idx;
			pol = (replace_pol == bsac_pkg::POL_SPARE) ? bsac_pkg::POL_LRU : replace_pol;
			if (op == bsac_pkg::OP_READ || op == bsac_pkg::OP_WRITE) begin
				for (int i = 0; i < bsac_pkg::NUM_WAYS; i++)
					if (lines[row][i].valid && lines[row][i].tag == tag) begin
						r.hit = 1'b1;
						r.way = 2'(i);
					end
				if (r.hit) begin
					if (pol == bsac_pkg::POL_LRU)
						promote(row, r.way);
					if (op == bsac_pkg::OP_WRITE) begin
						lines[row][r.way].dirty = 1'b1;
						if (write_pol == bsac_pkg::WP_THROUGH) begin
							r.wt_valid = 1'b1;
							r.wt_addr = addr;
						end
					end
				end
			end else if (op == bsac_pkg::OP_FILL) begin
				v = choose_victim(pol, row);
				if (write_pol == bsac_pkg::WP_BACK && lines[row][v].valid &&
					lines[row][v].dirty) begin
					r.wb_valid = 1'b1;
					r.wb_addr = {lines[row][v].tag, set_idx, bank,
						{bsac_pkg::OFFSET_BITS{1'b0}}};
				end
				lines[row][v].tag = tag;
				lines[row][v].valid = 1'b1;
				lines[row][v].dirty = 1'b0;
				if (pol != bsac_pkg::POL_RANDOM) begin
					ages[row][v] = bsac_pkg::AGE_W'(bsac_pkg::NUM_WAYS);
					for (int i = 0; i < bsac_pkg::NUM_WAYS; i++)
						if (ages[row][i] != 0)
							ages[row][i]--;
				end
				r.way = 2'(v);
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(tag_result_t got);
			tag_result_t e;
			if (pending.size() == 0) begin
				$error("result item arrived with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, got.hit);
				errors++;
			end
			if (got.way !== e.way) begin
				$error("way_used: expected %0d, got %0d", e.way, got.way);
				errors++;
			end
			if (got.wb_valid !== e.wb_valid) begin
				$error("writeback_valid: expected %0d, got %0d", e.wb_valid, got.wb_valid);
				errors++;
			end
			if (got.wb_addr !== e.wb_addr) begin
				$error("writeback_address: expected %h, got %h", e.wb_addr, got.wb_addr);
				errors++;
			end
			if (got.wt_valid !== e.wt_valid) begin
				$error("writethrough_valid: expected %0d, got %0d", e.wt_valid, got.wt_valid);
				errors++;
			end
			if (got.wt_addr !== e.wt_addr) begin
				$error("writethrough_address: expected %h, got %h", e.wt_addr, got.wt_addr);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bsac_req_if req_ch ();
	bsac_rsp_if rsp_ch ();

	banked_set_assoc_cache_tags_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	tag_scoreboard tags_sb = new();
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		tag_result_t got;
		if (arst_n && req_ch.valid && req_ch.ready)
			tags_sb.note_request(bsac_pkg::op_t'(req_ch.operation), req_ch.word_address);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.hit = rsp_ch.hit;
			got.way = rsp_ch.way_used;
			got.wb_valid = rsp_ch.writeback_valid;
			got.wb_addr = rsp_ch.writeback_address;
			got.wt_valid = rsp_ch.writethrough_valid;
			got.wt_addr = rsp_ch.writethrough_address;
			tags_sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** banked_set_assoc_cache_tags_core: FAILED **");
			$finish;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(bsac_pkg::op_t op, logic [31:0] addr);
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.word_address <= addr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (sender_idles && $urandom_range(0, 7) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tags_sb.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(bsac_pkg::reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bsac_pkg::REG_REPLACE)
			tags_sb.replace_pol = bsac_pkg::pol_t'(value[1:0]);
		else
			tags_sb.write_pol = bsac_pkg::wpol_t'(value[0]);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		logic [bsac_pkg::TAG_W-1:0] tag;
		a = $urandom();
		if ($urandom_range(0, 9) == 0)
			return a;
		case ($urandom_range(0, 3))
			0: tag = '0;
			1: tag = '1;
			default: tag = bsac_pkg::TAG_W'($urandom_range(0, 6));
		endcase
		a[bsac_pkg::ADDR_W-1 -: bsac_pkg::TAG_W] = tag;
		a[bsac_pkg::OFFSET_BITS + bsac_pkg::BANK_W +: bsac_pkg::SET_W] =
			($urandom_range(0, 3) == 0) ? bsac_pkg::SET_W'(63) :
			bsac_pkg::SET_W'($urandom_range(0, 2));
		return a;
	endfunction

	function automatic bsac_pkg::op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return bsac_pkg::OP_READ;
		if (r < 65)
			return bsac_pkg::OP_WRITE;
		if (r < 97)
			return bsac_pkg::OP_FILL;
		return bsac_pkg::OP_NONE;
	endfunction

	initial begin
		logic [31:0] a;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = bsac_pkg::OP_READ;
		req_ch.word_address = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(bsac_pkg::OP_READ, 32'h0);
		send_request(bsac_pkg::OP_FILL, 32'h0);
		send_request(bsac_pkg::OP_READ, 32'h7);
		send_request(bsac_pkg::OP_WRITE, 32'h0);
		send_request(bsac_pkg::OP_READ, 32'hFFFF_FFFF);
		send_request(bsac_pkg::OP_FILL, 32'hFFFF_FFFF);
		send_request(bsac_pkg::OP_WRITE, 32'hFFFF_FFFF);
		for (int i = 1; i <= 5; i++)
			send_request(bsac_pkg::OP_FILL, {21'(i), 11'h0});
		send_request(bsac_pkg::OP_FILL, 32'h0000_1000);
		send_request(bsac_pkg::OP_FILL, 32'h0000_1000);
		send_request(bsac_pkg::OP_READ, 32'h0000_1000);
		send_request(bsac_pkg::OP_WRITE, 32'h0000_1000);
		send_request(bsac_pkg::OP_NONE, 32'hFFFF_FFFF);
		send_request(bsac_pkg::OP_NONE, 32'h0);
		send_request(bsac_pkg::OP_READ, 32'h0000_0800);
		send_request(bsac_pkg::OP_WRITE, 32'h5555_AAAA);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_RANDOM));
					write_reg(bsac_pkg::REG_WRITE, 32'(bsac_pkg::WP_THROUGH));
				end
				1: begin
					write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_FIFO));
					write_reg(bsac_pkg::REG_WRITE, 32'(bsac_pkg::WP_BACK));
				end
				2: begin
					write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_SPARE));
					write_reg(bsac_pkg::REG_WRITE, 32'(bsac_pkg::WP_THROUGH));
				end
				3: begin
					write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_LRU));
					write_reg(bsac_pkg::REG_WRITE, 32'(bsac_pkg::WP_BACK));
				end
				4: write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_RANDOM));
				5: begin
					write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_FIFO));
					write_reg(bsac_pkg::REG_WRITE, 32'(bsac_pkg::WP_THROUGH));
				end
				6: write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_LRU));
				default: begin
					write_reg(bsac_pkg::REG_REPLACE, 32'(bsac_pkg::POL_LRU));
					write_reg(bsac_pkg::REG_WRITE, 32'(bsac_pkg::WP_BACK));
					sender_idles = 1'b0;
					receiver_idles = 1'b0;
				end
			endcase
			if (phase == 3)
				hold_request = 1'b1;
			for (int n = 0; n < 210; n++) begin
				a = pick_address();
				send_request(pick_op(), a);
			end
			drain();
		end

		if (tags_sb.errors == 0 && tags_sb.pending.size() == 0)
			$display("** banked_set_assoc_cache_tags_core: PASSED **");
		else
			$display("** banked_set_assoc_cache_tags_core: FAILED **");
		$finish;
	end
endmodule
